@@ hw/rtl/dmgs_pkg.sv @@
// shared types and constants for the dual motor gantry synchronizer
package dmgs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned TS_W   = 16;
  localparam int unsigned ACC_W  = 50;
  localparam int unsigned MAG_W  = 31;

  localparam logic [TS_W-1:0]   TS_RESET  = 16'd65;
  localparam logic [TS_W-1:0]   CORR_MAX  = 16'd32768;
  localparam logic [DATA_W-1:0] POS_MAX   = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] NEG_MIN   = 32'h8000_0000;

  typedef enum logic [2:0] {
    REG_GAIN_A       = 3'd0,
    REG_GAIN_B       = 3'd1,
    REG_GAIN_C       = 3'd2,
    REG_TIME_STEP    = 3'd3,
    REG_UPPER_FIRST  = 3'd4,
    REG_LOWER_FIRST  = 3'd5,
    REG_UPPER_SECOND = 3'd6,
    REG_LOWER_SECOND = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] gain_a;
    logic [DATA_W-1:0] gain_b;
    logic [DATA_W-1:0] gain_c;
    logic [TS_W-1:0]   time_step;
    logic [DATA_W-1:0] upper_first;
    logic [DATA_W-1:0] lower_first;
    logic [DATA_W-1:0] upper_second;
    logic [DATA_W-1:0] lower_second;
  } cfg_t;

  typedef enum logic [1:0] {
    MS_GAIN_A,
    MS_GAIN_B,
    MS_GAIN_C,
    MS_TIME_STEP
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     halt_load;
    logic     acc_load;
    logic     acc_add;
    logic     hist_upd;
    logic     mag_load;
    logic     corr_load;
    logic     out_load;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_SUM,
    ST_MAG,
    ST_SCALE,
    ST_CORR,
    ST_FINISH
  } state_t;

endpackage

@@ hw/rtl/dual_motor_gantry_sync.sv @@
// top level: config registers, sequencer and datapath of the gantry synchronizer
// an accepted input beat runs the nine-step sequence around the single
//   32x32 multiplier (three pid terms and the dt scaling, one product per cycle);
//   out_valid rises when the result is loaded, and no new beat is taken before then;
//   the next beat is taken the cycle after the result is loaded
// a stalled result holds the sequencer in its last step until the output frees
// reset (rst_n low, synchronous): gains 0, dt 65, limits fully open, error history 0
module dual_motor_gantry_sync (
  input  logic        clk,
  input  logic        rst_n,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_axis_select,
  input  logic [31:0] in_left_position,
  input  logic [31:0] in_right_position,
  input  logic [31:0] in_target_velocity,
  input  logic        in_safe_mode,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_left_command,
  output logic [31:0] out_left_velocity,
  output logic        out_right_command,
  output logic [31:0] out_right_velocity,
  output logic        out_limit_hit,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dmgs_pkg::*;

  cfg_t    cfg_r;
  dp_cmd_t cmd;

  // config writes are always taken; the user must write the block only while idle, it does not enforce this
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_a       <= '0;
      cfg_r.gain_b       <= '0;
      cfg_r.gain_c       <= '0;
      cfg_r.time_step    <= TS_RESET;
      cfg_r.upper_first  <= POS_MAX;
      cfg_r.lower_first  <= NEG_MIN;
      cfg_r.upper_second <= POS_MAX;
      cfg_r.lower_second <= NEG_MIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_GAIN_A:       cfg_r.gain_a       <= cfg_data;
        REG_GAIN_B:       cfg_r.gain_b       <= cfg_data;
        REG_GAIN_C:       cfg_r.gain_c       <= cfg_data;
        // dt is q0.16, only the low half of the beat counts
        REG_TIME_STEP:    cfg_r.time_step    <= cfg_data[TS_W-1:0];
        REG_UPPER_FIRST:  cfg_r.upper_first  <= cfg_data;
        REG_LOWER_FIRST:  cfg_r.lower_first  <= cfg_data;
        REG_UPPER_SECOND: cfg_r.upper_second <= cfg_data;
        REG_LOWER_SECOND: cfg_r.lower_second <= cfg_data;
        default:          cfg_r.gain_a       <= cfg_r.gain_a;
      endcase
    end
  end

  // state machine: capture, three pid products, sum, magnitude, dt product,
  // correction cap, then velocity select into the output register
  dmgs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // datapath keeps the two-deep error history of each axis pair
  dmgs_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg                (cfg_r),
    .in_axis_select     (in_axis_select),
    .in_left_position   (in_left_position),
    .in_right_position  (in_right_position),
    .in_target_velocity (in_target_velocity),
    .in_safe_mode       (in_safe_mode),
    .out_left_command   (out_left_command),
    .out_left_velocity  (out_left_velocity),
    .out_right_command  (out_right_command),
    .out_right_velocity (out_right_velocity),
    .out_limit_hit      (out_limit_hit)
  );

  // an accepted beat keeps the input side busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after a beat");

  // halt flags always agree in a presented result
  a_halt_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_command == out_limit_hit && out_right_command == out_limit_hit))
    else $error("halt flags disagree");

  // the output register is never reloaded over a result still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result overwritten while stalled");

  // the error history moves only while the input side is busy
  a_hist_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.hist_upd |-> in_stall)
    else $error("history update outside a tick");

endmodule

@@ hw/rtl/dmgs_ctrl.sv @@
// sequencer for one tick: shared multiplier steps and output handoff
module dmgs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic              out_valid,
  output dmgs_pkg::dp_cmd_t cmd
);
  import dmgs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_MUL_A;
      ST_MUL_A:  state_nxt = ST_MUL_B;
      ST_MUL_B:  state_nxt = ST_MUL_C;
      ST_MUL_C:  state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_CORR;
      ST_CORR:   state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MS_GAIN_A;
    unique case (state_r)
      ST_IDLE:   cmd.load_in = in_valid;
      ST_MUL_A: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MS_GAIN_A;
        cmd.halt_load = 1'b1;
      end
      ST_MUL_B: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MS_GAIN_B;
        cmd.acc_load = 1'b1;
      end
      ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_GAIN_C;
        cmd.acc_add = 1'b1;
      end
      ST_SUM: begin
        cmd.acc_add  = 1'b1;
        cmd.hist_upd = 1'b1;
      end
      ST_MAG:    cmd.mag_load = 1'b1;
      ST_SCALE: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TIME_STEP;
      end
      ST_CORR:   cmd.corr_load = 1'b1;
      ST_FINISH: cmd.out_load = !out_valid_r || !out_stall;
      default:   cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ hw/rtl/dmgs_dpath.sv @@
// datapath: error history, shared multiplier, accumulator and output register
module dmgs_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  dmgs_pkg::dp_cmd_t cmd,
  input  dmgs_pkg::cfg_t    cfg,
  input  logic              in_axis_select,
  input  logic [31:0]       in_left_position,
  input  logic [31:0]       in_right_position,
  input  logic [31:0]       in_target_velocity,
  input  logic              in_safe_mode,
  output logic              out_left_command,
  output logic [31:0]       out_left_velocity,
  output logic              out_right_command,
  output logic [31:0]       out_right_velocity,
  output logic              out_limit_hit
);
  import dmgs_pkg::*;

  logic              axis_r, safe_r;
  logic [DATA_W-1:0] left_r, right_r, target_r, err_r;
  logic [DATA_W-1:0] err_last_r [2];
  logic [DATA_W-1:0] err_prev_r [2];
  logic              halt_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic              neg_r, big_r;
  logic [MAG_W-1:0]  mag_r;
  logic [TS_W-1:0]   corr_r;

  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] err_sat;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [2*DATA_W-1:0] prod;
  logic [ACC_W-1:0]  prod_q;
  logic [ACC_W-1:0]  abs_u;
  logic [DATA_W:0]   pos_sum;
  logic signed [DATA_W-1:0] mean, upper, lower;
  logic [MAG_W-1:0]  scaled;
  logic [TS_W-1:0]   corr;
  logic [DATA_W-1:0] adjusted;
  logic              left_slowed;

  // saturated left minus right
  assign diff    = {in_left_position[31], in_left_position}
                 - {in_right_position[31], in_right_position};
  assign err_sat = (diff[DATA_W] != diff[DATA_W-1]) ? (diff[DATA_W] ? NEG_MIN : POS_MAX)
                                                    : diff[DATA_W-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MS_GAIN_A: begin
        op_a = $signed(cfg.gain_a);
        op_b = $signed(err_r);
      end
      MS_GAIN_B: begin
        op_a = $signed(cfg.gain_b);
        op_b = $signed(err_last_r[axis_r]);
      end
      MS_GAIN_C: begin
        op_a = $signed(cfg.gain_c);
        op_b = $signed(err_prev_r[axis_r]);
      end
      MS_TIME_STEP: begin
        op_a = $signed({1'b0, mag_r});
        op_b = $signed({{(DATA_W-TS_W){1'b0}}, cfg.time_step});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod   = op_a * op_b;
  // product taken to q16.16 by a floor shift, sign-extended to the accumulator
  assign prod_q = {{(ACC_W-48){prod_r[2*DATA_W-1]}}, prod_r[2*DATA_W-1:16]};
  assign abs_u  = acc_r[ACC_W-1] ? (~acc_r + 1'b1) : acc_r;

  // floor of the mean position and the limits of the selected axis
  assign pos_sum = {left_r[31], left_r} + {right_r[31], right_r};
  assign mean    = $signed(pos_sum[DATA_W:1]);
  assign upper   = $signed(axis_r ? cfg.upper_second : cfg.upper_first);
  assign lower   = $signed(axis_r ? cfg.lower_second : cfg.lower_first);

  // magnitudes at or above 2^31 always saturate the correction unless dt is zero
  assign scaled = prod_r[46:16];
  always_comb begin
    if (big_r) begin
      corr = (cfg.time_step != '0) ? CORR_MAX : '0;
    end else if (scaled > MAG_W'(CORR_MAX)) begin
      corr = CORR_MAX;
    end else begin
      corr = scaled[TS_W-1:0];
    end
  end

  // negative target adds, otherwise subtracts; neither can overflow
  assign adjusted    = target_r[31] ? (target_r + {16'b0, corr_r})
                                    : (target_r - {16'b0, corr_r});
  assign left_slowed = (neg_r == target_r[31]);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      axis_r   <= in_axis_select;
      safe_r   <= in_safe_mode;
      left_r   <= in_left_position;
      right_r  <= in_right_position;
      target_r <= in_target_velocity;
      err_r    <= err_sat;
    end
    if (cmd.halt_load) halt_r <= safe_r && ((mean > upper) || (mean < lower));
    if (cmd.mul_en) prod_r <= prod;
    if (cmd.acc_load) begin
      acc_r <= prod_q;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + prod_q;
    end
    if (cmd.mag_load) begin
      neg_r <= acc_r[ACC_W-1];
      big_r <= |abs_u[ACC_W-1:MAG_W];
      mag_r <= abs_u[MAG_W-1:0];
    end
    if (cmd.corr_load) corr_r <= corr;
    if (cmd.out_load) begin
      out_left_command   <= halt_r;
      out_right_command  <= halt_r;
      out_limit_hit      <= halt_r;
      out_left_velocity  <= left_slowed ? adjusted : target_r;
      out_right_velocity <= left_slowed ? target_r : adjusted;
    end
  end

  // per-axis error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        err_last_r[i] <= '0;
        err_prev_r[i] <= '0;
      end
    end else if (cmd.hist_upd) begin
      err_prev_r[axis_r] <= err_last_r[axis_r];
      err_last_r[axis_r] <= err_r;
    end
  end

endmodule
